>>> hdl/tcce_pkg.sv
// Shared types and codes for the text console cursor engine.
`default_nettype none

package tcce_pkg;

  // Request types on the input channel
  localparam logic [1:0] REQ_CHAR  = 2'd0;
  localparam logic [1:0] REQ_BLINK = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Drawing commands on the result channel
  localparam logic [2:0] CMD_GLYPH  = 3'd0;
  localparam logic [2:0] CMD_BLANK  = 3'd1;
  localparam logic [2:0] CMD_INVERT = 3'd2;
  localparam logic [2:0] CMD_SCROLL = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  // Control characters
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // Configuration register indexes
  localparam logic [1:0] CFG_COLS  = 2'd0;
  localparam logic [1:0] CFG_ROWS  = 2'd1;
  localparam logic [1:0] CFG_TAB   = 2'd2;
  localparam logic [1:0] CFG_BLINK = 2'd3;

  // Reset values of the configuration registers
  localparam logic [7:0] COLS_RST  = 8'd40;
  localparam logic [5:0] ROWS_RST  = 6'd24;
  localparam logic [4:0] TAB_RST   = 5'd4;
  localparam logic       BLINK_RST = 1'b1;

  localparam logic [4:0] TAB_MAX = 5'd16;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_PRINT,
    OP_NEWLINE,
    OP_TAB,
    OP_BS,
    OP_BLINK,
    OP_CLEAR
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] glyph;
  } op_t;

  // Effective (already clamped) screen settings
  typedef struct packed {
    logic [7:0] cols;
    logic [5:0] rows;
    logic [4:0] ts;
  } geom_t;

  // One drawing command
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] col;
    logic [5:0] row;
    logic [7:0] glyph;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/tcce_front.sv
// Request decoder: classifies console requests into sequencer operations.
`default_nettype none

module tcce_front (
  input  wire logic            in_push,
  output logic                 in_full,
  input  wire logic [1:0]      in_req_type,
  input  wire logic [7:0]      in_char_code,
  input  wire logic            blink_en,
  input  wire logic            opq_full,
  output logic                 opq_push,
  output tcce_pkg::op_t        opq_data
);
  import tcce_pkg::*;

  logic keep;

  always_comb begin
    keep           = 1'b0;
    opq_data.kind  = OP_PRINT;
    opq_data.glyph = in_char_code;
    unique case (in_req_type)
      REQ_CHAR: begin
        keep = 1'b1;
        if (in_char_code == CH_CR || in_char_code == CH_LF) begin
          opq_data.kind = OP_NEWLINE;
        end else if (in_char_code == CH_TAB) begin
          opq_data.kind = OP_TAB;
        end else if (in_char_code == CH_BS) begin
          opq_data.kind = OP_BS;
        end else begin
          opq_data.kind = OP_PRINT;
        end
      end
      REQ_BLINK: begin
        // blink ticks with blinking off give nothing, drop them here
        keep          = blink_en;
        opq_data.kind = OP_BLINK;
      end
      REQ_CLEAR: begin
        keep          = 1'b1;
        opq_data.kind = OP_CLEAR;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_full  = opq_full;
  assign opq_push = in_push && !opq_full && keep;

endmodule

`default_nettype wire

>>> hdl/tcce_opq.sv
// Four-entry operation queue between decoder and sequencer.
`default_nettype none

module tcce_opq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire tcce_pkg::op_t din,
  input  wire logic          pop,
  output tcce_pkg::op_t      dout,
  output logic               full,
  output logic               empty
);
  import tcce_pkg::*;

  op_t        mem_r [4];
  logic [1:0] wp_r, wp_nxt;
  logic [1:0] rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 3'd4);
  assign empty = (cnt_r == 3'd0);
  assign dout  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 2'd1 : wp_r;
    rp_nxt  = pop ? rp_r + 2'd1 : rp_r;
    cnt_nxt = cnt_r + {2'b00, push} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

`default_nettype wire

>>> hdl/tcce_back.sv
// Cursor sequencer: holds the cursor and emits drawing commands.
`default_nettype none

module tcce_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire tcce_pkg::geom_t geom,
  input  wire logic            opq_empty,
  input  wire tcce_pkg::op_t   opq_data,
  output logic                 opq_pop,
  output logic                 out_empty,
  input  wire logic            out_pop,
  output tcce_pkg::res_t       out_res
);
  import tcce_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_HIDE,
    S_MAIN,
    S_SCROLL
  } state_t;

  state_t     state_r, state_nxt;
  op_t        op_r, op_nxt;
  logic [7:0] col_r, col_nxt;
  logic [5:0] row_r, row_nxt;
  logic       shown_r, shown_nxt;
  logic [4:0] rem_r, rem_nxt;
  logic [2:0] bit_r, bit_nxt;

  // result queue, two entries
  res_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  logic       emit, can, out_push, out_take;
  res_t       em;

  logic [8:0] col_inc;
  logic [6:0] row_inc;
  logic       wrap, row_full, scroll, cont;
  logic [7:0] col_after;
  logic [5:0] row_after;
  logic [4:0] rem_inc, rem_next, sh;
  logic [7:0] gl;

  always_comb begin
    col_inc   = {1'b0, col_r} + 9'd1;
    row_inc   = {1'b0, row_r} + 7'd1;
    wrap      = col_inc >= {1'b0, geom.cols};
    row_full  = row_inc >= {1'b0, geom.rows};
    scroll    = wrap && row_full;
    col_after = wrap ? 8'd0 : col_inc[7:0];
    row_after = !wrap ? row_r : (row_full ? geom.rows - 6'd1 : row_inc[5:0]);
    rem_inc   = rem_r + 5'd1;
    rem_next  = (rem_inc == geom.ts) ? 5'd0 : rem_inc;
    cont      = (op_r.kind == OP_TAB) && !wrap && (rem_next != 5'd0);
    // one restoring step of col % ts, MSB first
    sh        = {rem_r[3:0], col_r[bit_r]};
    gl        = (op_r.kind == OP_TAB) ? CH_SPACE : op_r.glyph;
  end

  assign can = (cnt_r != 2'd2);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    shown_nxt = shown_r;
    rem_nxt   = rem_r;
    bit_nxt   = bit_r;
    opq_pop   = 1'b0;
    emit      = 1'b0;
    em        = '{cmd: CMD_BLANK, col: col_r, row: row_r, glyph: 8'd0, last: 1'b1};

    unique case (state_r)
      S_IDLE: begin
        if (!opq_empty) begin
          opq_pop = 1'b1;
          op_nxt  = opq_data;
          if (opq_data.kind == OP_TAB) begin
            rem_nxt   = 5'd0;
            bit_nxt   = 3'd7;
            state_nxt = S_MOD;
          end else begin
            state_nxt = S_HIDE;
          end
        end
      end

      S_MOD: begin
        rem_nxt = (sh >= geom.ts) ? sh - geom.ts : sh;
        bit_nxt = bit_r - 3'd1;
        if (bit_r == 3'd0) begin
          state_nxt = S_HIDE;
        end
      end

      S_HIDE: begin
        if (op_r.kind == OP_BS && col_r == 8'd0) begin
          state_nxt = S_IDLE;
        end else if (shown_r && op_r.kind != OP_BLINK) begin
          emit    = 1'b1;
          em.last = (op_r.kind == OP_NEWLINE) && !row_full;
          if (can) begin
            shown_nxt = 1'b0;
            state_nxt = S_MAIN;
          end
        end else begin
          state_nxt = S_MAIN;
        end
      end

      S_MAIN: begin
        unique case (op_r.kind)
          OP_PRINT, OP_TAB: begin
            emit     = 1'b1;
            em.cmd   = CMD_GLYPH;
            em.glyph = gl;
            em.last  = !scroll && !cont;
            if (can) begin
              col_nxt = col_after;
              row_nxt = row_after;
              rem_nxt = rem_next;
              if (scroll) begin
                state_nxt = S_SCROLL;
              end else if (cont) begin
                state_nxt = S_MAIN;
              end else begin
                state_nxt = S_IDLE;
              end
            end
          end
          OP_NEWLINE: begin
            emit   = row_full;
            em.cmd = CMD_SCROLL;
            em.col = 8'd0;
            em.row = 6'd0;
            if (!row_full || can) begin
              col_nxt   = 8'd0;
              row_nxt   = row_full ? geom.rows - 6'd1 : row_inc[5:0];
              state_nxt = S_IDLE;
            end
          end
          OP_BS: begin
            emit   = 1'b1;
            em.col = col_r - 8'd1;
            if (can) begin
              col_nxt   = col_r - 8'd1;
              state_nxt = S_IDLE;
            end
          end
          OP_BLINK: begin
            emit   = 1'b1;
            em.cmd = CMD_INVERT;
            if (can) begin
              shown_nxt = !shown_r;
              state_nxt = S_IDLE;
            end
          end
          OP_CLEAR: begin
            emit   = 1'b1;
            em.cmd = CMD_CLEAR;
            em.col = 8'd0;
            em.row = 6'd0;
            if (can) begin
              col_nxt   = 8'd0;
              row_nxt   = 6'd0;
              state_nxt = S_IDLE;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_SCROLL: begin
        emit   = 1'b1;
        em.cmd = CMD_SCROLL;
        em.col = 8'd0;
        em.row = 6'd0;
        if (can) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_push  = emit && can;
  assign out_take  = out_pop && (cnt_r != 2'd0);
  assign out_empty = (cnt_r == 2'd0);
  assign out_res   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_r   <= 8'd0;
      row_r   <= 6'd0;
      shown_r <= 1'b0;
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
      cnt_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      shown_r <= shown_nxt;
      wp_r    <= wp_r ^ out_push;
      rp_r    <= rp_r ^ out_take;
      cnt_r   <= cnt_r + {1'b0, out_push} - {1'b0, out_take};
    end
    op_r  <= op_nxt;
    rem_r <= rem_nxt;
    bit_r <= bit_nxt;
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      q_r[wp_r] <= em;
    end
  end

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result queue count out of range");

  a_rem_lt_ts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD) |-> (rem_r < geom.ts))
    else $error("tab remainder not below tab stop");

  a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
    (out_push && em.cmd == CMD_CLEAR) |=> (col_r == 8'd0 && row_r == 6'd0))
    else $error("cursor not homed after clear");

  a_invert_toggles: assert property (@(posedge clk) disable iff (!rst_n)
    (out_push && em.cmd == CMD_INVERT) |=> (shown_r != $past(shown_r)))
    else $error("cursor flag not toggled by invert");

endmodule

`default_nettype wire

>>> hdl/text_console_cursor_engine.sv
// Top level of the text console cursor engine.
`default_nettype none

// Channel   Ports                                         Handshake
// input     in_req_type, in_char_code                     in_push / in_full
// result    out_command, out_cell_col, out_cell_row,
//           out_glyph, out_last                           out_pop / out_empty
// config    cfg_index, cfg_wdata                          cfg_we (no wait)
//
// Flow: a request leaves the op queue, passes the cursor hide step and then
//   emits commands at one per cycle while the result queue has room; a tab first
//   finds the column remainder (bit-serial restoring divide), then emits spaces.
// Reset: synchronous, clears cursor to 0,0 hidden and loads register defaults.
// Stalls: a 4-deep op queue decouples the input; a 2-deep result queue lets the
//   sequencer run ahead while the sink holds pop low.

module text_console_cursor_engine (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // request channel
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [1:0] in_req_type,
  input  wire logic [7:0] in_char_code,
  // command channel
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [2:0]      out_command,
  output logic [7:0]      out_cell_col,
  output logic [5:0]      out_cell_row,
  output logic [7:0]      out_glyph,
  output logic            out_last,
  // register writes
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata
);
  import tcce_pkg::*;

  // raw register values as written
  logic [7:0] cols_r;
  logic [5:0] rows_r;
  logic [4:0] ts_r;
  logic       blink_r;

  geom_t      geom;
  logic       opq_full, opq_push, opq_pop, opq_empty;
  op_t        opq_din, opq_dout;
  res_t       res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= COLS_RST;
      rows_r  <= ROWS_RST;
      ts_r    <= TAB_RST;
      blink_r <= BLINK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLS:  cols_r  <= cfg_wdata;
        CFG_ROWS:  rows_r  <= cfg_wdata[5:0];
        CFG_TAB:   ts_r    <= cfg_wdata[4:0];
        CFG_BLINK: blink_r <= cfg_wdata[0];
      endcase
    end
  end

  // zero-size screen acts as one cell; tab stop clamps to 1..16
  always_comb begin
    geom.cols = (cols_r == 8'd0) ? 8'd1 : cols_r;
    geom.rows = (rows_r == 6'd0) ? 6'd1 : rows_r;
    if (ts_r == 5'd0) begin
      geom.ts = 5'd1;
    end else if (ts_r > TAB_MAX) begin
      geom.ts = TAB_MAX;
    end else begin
      geom.ts = ts_r;
    end
  end

  tcce_front u_front (
    .in_push      (in_push),
    .in_full      (in_full),
    .in_req_type  (in_req_type),
    .in_char_code (in_char_code),
    .blink_en     (blink_r),
    .opq_full     (opq_full),
    .opq_push     (opq_push),
    .opq_data     (opq_din)
  );

  tcce_opq u_opq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (opq_push),
    .din   (opq_din),
    .pop   (opq_pop),
    .dout  (opq_dout),
    .full  (opq_full),
    .empty (opq_empty)
  );

  tcce_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .opq_empty (opq_empty),
    .opq_data  (opq_dout),
    .opq_pop   (opq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (res)
  );

  assign out_command  = res.cmd;
  assign out_cell_col = res.col;
  assign out_cell_row = res.row;
  assign out_glyph    = res.glyph;
  assign out_last     = res.last;

endmodule

`default_nettype wire
